// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority request queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;
	localparam int unsigned REQ_W   = 16;
	localparam int unsigned PRIO_W  = 8;
	localparam int unsigned BOOK_W  = 16;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned COUNT_W = 5;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DROP   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [BOOK_W-1:0] book;
		logic [PRIO_W-1:0] priority_lvl;
		logic [REQ_W-1:0]  requester;
	} item_t;

	typedef struct packed {
		logic  ins;
		logic  pop;
		item_t item;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted shift chain: holds, shifts right on insert, shifts
// left on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
	input  wire                  clk,
	input  spq_pkg::cell_ctrl_t  ctrl,
	input  wire                  occupied,
	input  spq_pkg::item_t       left_item,
	input  wire                  left_after,
	input  spq_pkg::item_t       right_item,
	output spq_pkg::item_t       item_q,
	output logic                 after
);

	spq_pkg::item_t item_d;

	// new item goes behind every entry with priority <= its own
	assign after = occupied && (item_q.priority_lvl <= ctrl.item.priority_lvl);

	always_comb begin
		item_d = item_q;
		if (ctrl.ins) begin
			if (after) begin
				item_d = item_q;
			end else if (left_after) begin
				item_d = ctrl.item;
			end else begin
				item_d = left_item;
			end
		end else if (ctrl.pop) begin
			item_d = right_item;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
	end

endmodule

`default_nettype wire

// ===== rtl/core/stable_priority_request_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_request_queue
// Bounded priority queue of requests built as a chain of shift cells.
// ----------------------------------------------------------------------------
// One transfer in, one transfer out per operation; the compare-and-shift step of the
// cell chain and the reply are registered together, so the block sustains one
// operation per clock while the result side keeps up. Pop returns the lowest
// priority value first, equal priorities in arrival order; drop returns the tail.
// Insert on a full queue returns status full, pop or drop on an empty queue
// returns status empty; mode 3 is a no-op with status ok.
`default_nettype none

module stable_priority_request_queue #(
	parameter int unsigned QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,  // requester_id[15:0], priority_req[23:16], book_id[39:24]
	input  wire  [1:0]  s_tuser,  // mode[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,  // out_requester_id[15:0], out_priority[23:16],
	                              // out_book_id[39:24], entry_count[44:40], zero[47:45]
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned IW = $clog2(QUEUE_DEPTH);

	logic [CW-1:0]        count_q;
	logic                 out_valid_q;
	spq_pkg::item_t       out_item_q;
	logic [1:0]           out_status_q;

	spq_pkg::item_t       cell_item [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_after;
	logic [QUEUE_DEPTH-1:0] cell_occ;
	spq_pkg::cell_ctrl_t  ctrl;

	logic                 accept;
	logic [1:0]           mode;
	spq_pkg::item_t       in_item;
	logic                 full;
	logic                 empty;
	logic [IW-1:0]        tail_idx;
	logic [CW-1:0]        tail_cnt;
	logic [31:0]          count_ext;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign mode     = s_tuser;
	assign in_item  = s_tdata;
	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign tail_cnt = count_q - CW'(1);
	assign tail_idx = tail_cnt[IW-1:0];

	assign ctrl.ins  = accept && (mode == spq_pkg::MODE_INSERT) && !full;
	assign ctrl.pop  = accept && (mode == spq_pkg::MODE_POP) && !empty;
	assign ctrl.item = in_item;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		spq_pkg::item_t left_item;
		spq_pkg::item_t right_item;
		logic           left_after;

		assign cell_occ[i] = (CW'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_item  = in_item;
			assign left_after = 1'b1;
		end else begin : g_mid
			assign left_item  = cell_item[i-1];
			assign left_after = cell_after[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_item = cell_item[i];
		end else begin : g_inner
			assign right_item = cell_item[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (cell_occ[i]),
			.left_item  (left_item),
			.left_after (left_after),
			.right_item (right_item),
			.item_q     (cell_item[i]),
			.after      (cell_after[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				if (ctrl.ins) begin
					count_q <= count_q + CW'(1);
				end else if (!empty && ((mode == spq_pkg::MODE_POP) ||
						(mode == spq_pkg::MODE_DROP))) begin
					count_q <= count_q - CW'(1);
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q   <= '0;
			out_status_q <= spq_pkg::ST_OK;
			case (mode)
				spq_pkg::MODE_INSERT: begin
					if (full) begin
						out_status_q <= spq_pkg::ST_FULL;
					end
				end
				spq_pkg::MODE_POP: begin
					if (empty) begin
						out_status_q <= spq_pkg::ST_EMPTY;
					end else begin
						out_item_q <= cell_item[0];
					end
				end
				spq_pkg::MODE_DROP: begin
					if (empty) begin
						out_status_q <= spq_pkg::ST_EMPTY;
					end else begin
						out_item_q <= cell_item[tail_idx];
					end
				end
				default: begin
					out_status_q <= spq_pkg::ST_OK;
				end
			endcase
		end
	end

	assign count_ext = 32'(count_q);
	assign m_tvalid  = out_valid_q;
	assign m_tuser   = out_status_q;
	assign m_tdata   = {3'b000, count_ext[spq_pkg::COUNT_W-1:0], out_item_q};

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CW'(QUEUE_DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound)
		else $error("entry count exceeds depth");

	property p_full_flag;
		@(posedge clk) disable iff (!arst_n)
			(accept && (mode == spq_pkg::MODE_INSERT) && full)
			|=> (m_tvalid && (m_tuser == spq_pkg::ST_FULL) && $stable(count_q));
	endproperty
	a_full_flag: assert property (p_full_flag)
		else $error("insert into full queue not flagged");

	property p_head_sorted;
		@(posedge clk) disable iff (!arst_n)
			cell_occ[1] |-> (cell_item[0].priority_lvl <= cell_item[1].priority_lvl);
	endproperty
	a_head_sorted: assert property (p_head_sorted)
		else $error("head cells out of priority order");

	property p_empty_flag;
		@(posedge clk) disable iff (!arst_n)
			(accept && empty && ((mode == spq_pkg::MODE_POP) || (mode == spq_pkg::MODE_DROP)))
			|=> (m_tuser == spq_pkg::ST_EMPTY) && (count_q == '0);
	endproperty
	a_empty_flag: assert property (p_empty_flag)
		else $error("removal from empty queue not flagged");

endmodule

`default_nettype wire

// ===== bench/stable_priority_request_queue_test.sv =====
// ----------------------------------------------------------------------------
// stable_priority_request_queue_test
// Self-checking bench for the stable priority request queue. A backlog of
// insert, pop, drop and no-op requests is streamed in over four phases of
// varied source idling and sink stalls. Each accepted transfer is run through
// a local sorted-queue model and the predicted reply, status and all data
// fields, is compared with the output stream, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_priority_request_queue_test;

	localparam int unsigned DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH;
	localparam logic [spq_pkg::MODE_W-1:0] MODE_NOP = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned ITEMS_PER_PHASE = 152;

	typedef struct {
		logic [spq_pkg::MODE_W-1:0] mode;
		spq_pkg::item_t             item;
	} request_t;

	typedef struct packed {
		logic [spq_pkg::STAT_W-1:0]  status;
		logic [2:0]                  pad;
		logic [spq_pkg::COUNT_W-1:0] count;
		spq_pkg::item_t              entry;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	request_t backlog[$];
	reply_t   expected_replies[$];

	spq_pkg::item_t sorted_entries[DEPTH];
	int unsigned    held_count = 0;

	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	logic        in_taken = 1'b0;

	stable_priority_request_queue #(
		.QUEUE_DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sorted insert after equal priorities; pop takes head, drop takes tail.
	task automatic apply_request(input logic [spq_pkg::MODE_W-1:0] mode,
	                             input spq_pkg::item_t it);
		reply_t r;
		int unsigned pos;
		int unsigned i;
		r = '0;
		r.status = spq_pkg::ST_OK;
		case (mode)
			spq_pkg::MODE_INSERT: begin
				if (held_count >= DEPTH) begin
					r.status = spq_pkg::ST_FULL;
				end else begin
					pos = 0;
					while (pos < held_count &&
					       sorted_entries[pos].priority_lvl <= it.priority_lvl)
						pos++;
					for (i = held_count; i > pos; i--)
						sorted_entries[i] = sorted_entries[i - 1];
					sorted_entries[pos] = it;
					held_count++;
				end
			end
			spq_pkg::MODE_POP, spq_pkg::MODE_DROP: begin
				if (held_count == 0) begin
					r.status = spq_pkg::ST_EMPTY;
				end else if (mode == spq_pkg::MODE_POP) begin
					r.entry = sorted_entries[0];
					for (i = 1; i < held_count; i++)
						sorted_entries[i - 1] = sorted_entries[i];
					held_count--;
				end else begin
					r.entry = sorted_entries[held_count - 1];
					held_count--;
				end
			end
			default: ;
		endcase
		r.count = held_count[spq_pkg::COUNT_W-1:0];
		expected_replies.push_back(r);
	endtask

	task automatic queue_insert(input logic [15:0] req, input logic [7:0] prio,
	                            input logic [15:0] book);
		request_t q;
		q.mode = spq_pkg::MODE_INSERT;
		q.item.requester = req;
		q.item.priority_lvl = prio;
		q.item.book = book;
		backlog.push_back(q);
	endtask

	task automatic queue_cmd(input logic [spq_pkg::MODE_W-1:0] mode);
		request_t q;
		q.mode = mode;
		q.item = '0;
		backlog.push_back(q);
	endtask

	// Bursts lean toward filling or draining so the queue swings between
	// empty and full; half the priorities come from a tiny range to force ties.
	task automatic add_random(input int unsigned n);
		request_t q;
		int unsigned made;
		int unsigned burst;
		int unsigned fill_bias;
		int unsigned k;
		made = 0;
		while (made < n) begin
			burst = $urandom_range(24, 1);
			fill_bias = $urandom_range(1) ? 85 : 15;
			for (k = 0; k < burst && made < n; k++) begin
				q.item.requester = 16'($urandom);
				q.item.book = 16'($urandom);
				q.item.priority_lvl = $urandom_range(1) ? 8'($urandom_range(3))
				                                        : 8'($urandom_range(255));
				if ($urandom_range(99) < 3)
					q.mode = MODE_NOP;
				else if ($urandom_range(99) < fill_bias)
					q.mode = spq_pkg::MODE_INSERT;
				else
					q.mode = $urandom_range(1) ? spq_pkg::MODE_POP : spq_pkg::MODE_DROP;
				if (q.mode != MODE_NOP)
					made++;
				backlog.push_back(q);
			end
		end
	endtask

	task automatic add_directed();
		queue_cmd(spq_pkg::MODE_POP);
		queue_cmd(spq_pkg::MODE_DROP);
		queue_cmd(MODE_NOP);
		queue_insert(16'hFFFF, 8'hFF, 16'hFFFF);
		queue_insert(16'h0000, 8'h00, 16'h0000);
		queue_insert(16'h0001, 8'h80, 16'hA5A5);
		queue_insert(16'h0002, 8'h80, 16'h5A5A);
		queue_insert(16'h0003, 8'h00, 16'h1234);
		queue_insert(16'h0004, 8'hFF, 16'hFFFF);
		queue_insert(16'h0005, 8'h7F, 16'h0001);
		queue_insert(16'h0006, 8'h80, 16'h8000);
		queue_insert(16'h0007, 8'h01, 16'h00FF);
		queue_insert(16'h0008, 8'hFE, 16'hFF00);
		queue_insert(16'h0009, 8'h80, 16'h0F0F);
		queue_insert(16'h000A, 8'h00, 16'hF0F0);
		queue_insert(16'h000B, 8'h40, 16'h3333);
		queue_insert(16'h000C, 8'hC0, 16'hCCCC);
		queue_insert(16'h000D, 8'h80, 16'h5555);
		queue_insert(16'h000E, 8'h00, 16'hAAAA);
		queue_insert(16'h000F, 8'h10, 16'h7777);
		queue_cmd(MODE_NOP);
		queue_cmd(spq_pkg::MODE_POP);
		queue_cmd(spq_pkg::MODE_DROP);
	endtask

	always @(negedge clk) begin : driver
		request_t nxt;
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					nxt = backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.item;
					s_tuser <= nxt.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin : input_side
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			apply_request(s_tuser, spq_pkg::item_t'(s_tdata));
	end

	always @(posedge clk) begin : monitor
		reply_t got;
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata};
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply: status=%0d req=%h prio=%h book=%h count=%0d",
					         got.status, got.entry.requester, got.entry.priority_lvl,
					         got.entry.book, got.count);
			end else begin
				want = expected_replies.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("reply mismatch: exp status=%0d req=%h prio=%h book=%h count=%0d pad=%b",
						         want.status, want.entry.requester, want.entry.priority_lvl,
						         want.entry.book, want.count, want.pad);
						$display("                got status=%0d req=%h prio=%h book=%h count=%0d pad=%b",
						         got.status, got.entry.requester, got.entry.priority_lvl,
						         got.entry.book, got.count, got.pad);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("stable_priority_request_queue_test: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned ph;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
				default: begin src_idle_pct = 30; sink_stall_pct = 30; end
			endcase
			if (ph == 0)
				add_directed();
			add_random(ITEMS_PER_PHASE);
			while (backlog.size() != 0 || s_tvalid || expected_replies.size() != 0)
				@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("stable_priority_request_queue_test: PASS");
		else
			$display("stable_priority_request_queue_test: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_request_queue.sv
bench/stable_priority_request_queue_test.sv
